[hdl/ptd_pkg.sv]
// Package for the periodic task dispatcher: field widths, action and status codes,
// controller states and the status struct of the serial remainder unit.
// No dependencies.
package ptd_pkg;

    localparam int TICK_W             = 32;
    localparam int PERIOD_W           = 16;
    localparam int ACTION_W           = 3;
    localparam int STATUS_W           = 3;
    localparam int SLOT_IN_W          = 4;
    localparam int DSLOT_W            = 3;
    localparam int DEFAULT_TASK_SLOTS = 8;

    localparam logic [TICK_W-1:0] WRAP_LIMIT_RESET = {TICK_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_MODIFY = 3'd3,
        ACT_START  = 3'd4,
        ACT_STOP   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_STATE   = 3'd1,
        ST_ZERO_PERIOD = 3'd2,
        ST_TAKEN       = 3'd3,
        ST_RANGE       = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_NO_TASKS    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_status_t;

endpackage

[hdl/ptd_mod_serial.sv]
// Bit-serial remainder unit: tests whether a period divides the tick count,
// one dividend bit per cycle through a restoring shift-subtract step.
// Depends on ptd_pkg.
module ptd_mod_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ptd_pkg::TICK_W-1:0]    dividend,
    input  logic [ptd_pkg::PERIOD_W-1:0]  divisor,
    output ptd_pkg::mod_status_t          mod_st
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

    logic [TICK_W-1:0]   shift_reg, shift_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   trial;

    assign trial = {rem_reg, shift_reg[TICK_W-1]};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            shift_next = {shift_reg[TICK_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = PERIOD_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[PERIOD_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign mod_st.done     = done_reg;
    assign mod_st.rem_zero = (rem_reg == '0);

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start)
        else $error("remainder unit restarted while running");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(run_reg) && !run_reg))
        else $error("done without a finished run");
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");
`endif

endmodule

[hdl/periodic_task_dispatcher.sv]
// Periodic task dispatcher top level: slot table, tick counter, command decode and
// the scan controller that walks the slots on each tick.
// Depends on ptd_pkg and ptd_mod_serial.
//
// Usage: an item (action, task_slot, task_period) is taken at a rising edge where
// start is high and busy is low. Every result item shows on status, dispatch_valid,
// dispatch_slot, tick_value and last_result for exactly one cycle with
// result_strobe high; the receiver cannot hold results off, so nothing waits.
// Create, delete, modify, start, stop, and a tick while stopped, give one result in
// the cycle after the item is taken, and busy stays low: one such item per cycle.
// A tick while running raises busy and scans the slots in priority order. An empty
// slot is passed over in the scan state; an occupied slot waits in the divide state
// for the bit-serial remainder unit, which handles one tick-count bit per cycle.
// Dispatch results appear during the scan, and the last one is set by the finish state.
// tick_wrap_limit is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset empties the table, stops the scheduler, clears the tick counter and sets
// the wrap limit to all ones; stored periods are not cleared.
module periodic_task_dispatcher #(
    parameter int TASK_SLOTS = ptd_pkg::DEFAULT_TASK_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptd_pkg::ACTION_W-1:0]  action,
    input  logic [ptd_pkg::SLOT_IN_W-1:0] task_slot,
    input  logic [ptd_pkg::PERIOD_W-1:0]  task_period,
    input  logic                          cfg_wr_en,
    input  logic [ptd_pkg::TICK_W-1:0]    cfg_wr_data,
    output logic                          result_strobe,
    output logic [ptd_pkg::STATUS_W-1:0]  status,
    output logic                          dispatch_valid,
    output logic [ptd_pkg::DSLOT_W-1:0]   dispatch_slot,
    output logic [ptd_pkg::TICK_W-1:0]    tick_value,
    output logic                          last_result
);
    import ptd_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [SLOT_IN_W:0] SLOT_COUNT = (SLOT_IN_W + 1)'(TASK_SLOTS);

    state_t                  state_reg, state_next;
    logic [TICK_W-1:0]       limit_reg, limit_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic                    running_reg, running_next;
    logic [TASK_SLOTS-1:0]   valid_reg, valid_next;
    logic [PERIOD_W-1:0]     period_reg [TASK_SLOTS];
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [SLOT_W-1:0]       pend_slot_reg, pend_slot_next;
    logic                    strobe_reg, strobe_next;
    status_t                 status_reg, status_next;
    logic                    dv_reg, dv_next;
    logic [DSLOT_W-1:0]      dslot_reg, dslot_next;
    logic                    last_reg, last_next;

    logic                    accept;
    logic                    in_range;
    logic [SLOT_W-1:0]       wr_idx;
    logic                    period_we;
    logic                    cand;
    logic                    mod_start;
    logic [TICK_W-1:0]       tick_inc;
    logic [TICK_W-1:0]       tick_wrapped;
    mod_status_t             mod_st;

    assign accept       = start && (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign in_range     = ({1'b0, task_slot} < SLOT_COUNT);
    assign wr_idx       = SLOT_W'(task_slot);
    assign cand         = valid_reg[idx_reg] && (period_reg[idx_reg] != '0);
    assign tick_inc     = tick_reg + 1'b1;
    assign tick_wrapped = (tick_inc >= limit_reg) ? '0 : tick_inc;

    ptd_mod_serial u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (tick_reg),
        .divisor  (period_reg[idx_reg]),
        .mod_st   (mod_st)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_TICK) && running_reg)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (cand)
                begin
                    state_next = S_DIV;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (mod_st.done)
                begin
                    state_next = (idx_reg == LAST_IDX) ? S_FINISH : S_SCAN;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        tick_next      = tick_reg;
        running_next   = running_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        dv_next        = dv_reg;
        dslot_next     = dslot_reg;
        last_next      = last_reg;
        period_we      = 1'b0;
        mod_start      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_OK;
                    dv_next     = 1'b0;
                    dslot_next  = '0;
                    last_next   = 1'b1;
                    unique case (action)
                        ACT_TICK:
                        begin
                            if (running_reg)
                            begin
                                strobe_next = 1'b0;
                                tick_next   = tick_wrapped;
                                idx_next    = '0;
                                pend_next   = 1'b0;
                            end
                            else
                            begin
                                status_next = ST_BAD_STATE;
                            end
                        end
                        ACT_CREATE:
                        begin
                            priority if (task_period == '0)
                                status_next = ST_ZERO_PERIOD;
                            else if (!in_range)
                                status_next = ST_RANGE;
                            else if (valid_reg[wr_idx])
                                status_next = ST_TAKEN;
                            else
                            begin
                                valid_next[wr_idx] = 1'b1;
                                period_we          = 1'b1;
                            end
                        end
                        ACT_DELETE:
                        begin
                            priority if (!in_range)
                                status_next = ST_RANGE;
                            else if (!valid_reg[wr_idx])
                                status_next = ST_NOT_FOUND;
                            else
                                valid_next[wr_idx] = 1'b0;
                        end
                        ACT_MODIFY:
                        begin
                            priority if (task_period == '0)
                                status_next = ST_ZERO_PERIOD;
                            else if (!in_range)
                                status_next = ST_RANGE;
                            else if (!valid_reg[wr_idx])
                                status_next = ST_NOT_FOUND;
                            else
                                period_we = 1'b1;
                        end
                        ACT_START:
                        begin
                            priority if (valid_reg == '0)
                                status_next = ST_NO_TASKS;
                            else if (running_reg)
                                status_next = ST_BAD_STATE;
                            else
                                running_next = 1'b1;
                        end
                        ACT_STOP:
                        begin
                            if (!running_reg)
                            begin
                                status_next = ST_BAD_STATE;
                            end
                            else
                            begin
                                running_next = 1'b0;
                                tick_next    = '0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BAD_STATE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (cand)
                begin
                    mod_start = 1'b1;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (mod_st.done)
                begin
                    if (mod_st.rem_zero)
                    begin
                        pend_next      = 1'b1;
                        pend_slot_next = idx_reg;
                        if (pend_reg)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_OK;
                            dv_next     = 1'b1;
                            dslot_next  = DSLOT_W'({{DSLOT_W{1'b0}}, pend_slot_reg});
                            last_next   = 1'b0;
                        end
                    end
                    if (idx_reg != LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                strobe_next = 1'b1;
                status_next = ST_OK;
                dv_next     = pend_reg;
                dslot_next  = pend_reg ? DSLOT_W'({{DSLOT_W{1'b0}}, pend_slot_reg}) : '0;
                last_next   = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= WRAP_LIMIT_RESET;
            tick_reg    <= '0;
            running_reg <= 1'b0;
            valid_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            tick_reg    <= tick_next;
            running_reg <= running_next;
            valid_reg   <= valid_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        status_reg    <= status_next;
        dv_reg        <= dv_next;
        dslot_reg     <= dslot_next;
        last_reg      <= last_next;
        if (period_we)
        begin
            period_reg[wr_idx] <= task_period;
        end
    end

    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign dispatch_valid = dv_reg;
    assign dispatch_slot  = dslot_reg;
    assign tick_value     = tick_reg;
    assign last_result    = last_reg;

`ifndef ASSERT_OFF
    a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && dv_reg) |-> (status_reg == ST_OK))
        else $error("dispatch result with a failing status");
    a_scan_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> running_reg)
        else $error("slot scan while stopped");
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_TICK) && running_reg) |=> busy)
        else $error("running tick did not start a scan");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_st.done |-> (state_reg == S_DIV))
        else $error("remainder result outside the wait state");
    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> busy)
        else $error("non-final result after the scan ended");
`endif

endmodule

[test/periodic_task_dispatcher_test.sv]
// Self-checking testbench for periodic_task_dispatcher: a directed table of items, then
// random phases under several wrap limits, every result checked against a behavioural model or the table.
// Depends on ptd_pkg and the periodic_task_dispatcher RTL.
module periodic_task_dispatcher_test;
    import ptd_pkg::*;

    localparam int SLOTS         = DEFAULT_TASK_SLOTS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 184;
    localparam int PHASES        = 4;
    localparam int CALM_ITEMS    = 40;
    localparam int DIRECTED_ROWS = 27;

    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                dispatch_valid;
        logic [DSLOT_W-1:0]  dispatch_slot;
        logic [TICK_W-1:0]   tick_value;
        logic                last_result;
    } outcome_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [SLOT_IN_W-1:0] slot;
        logic [PERIOD_W-1:0]  period;
        logic                 typed;
        status_t              status;
        logic [TICK_W-1:0]    tick;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ACTION_W-1:0]  action;
    logic [SLOT_IN_W-1:0] task_slot;
    logic [PERIOD_W-1:0]  task_period;
    logic                 cfg_wr_en;
    logic [TICK_W-1:0]    cfg_wr_data;
    logic                 result_strobe;
    logic [STATUS_W-1:0]  status;
    logic                 dispatch_valid;
    logic [DSLOT_W-1:0]   dispatch_slot;
    logic [TICK_W-1:0]    tick_value;
    logic                 last_result;

    logic                 sched_valid [SLOTS];
    logic [PERIOD_W-1:0]  sched_period [SLOTS];
    logic [TICK_W-1:0]    sched_ticks;
    logic                 sched_running;
    logic [TICK_W-1:0]    sched_wrap;

    outcome_t             pending_outcomes [$];
    stim_row_t            directed_rows [DIRECTED_ROWS];

    logic                 item_typed;
    status_t              item_status;
    logic [TICK_W-1:0]    item_tick;

    int cycle_count;
    int errors;
    int items_accepted;
    int results_seen;
    int dispatches_seen;
    int wrap_settings;

    periodic_task_dispatcher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .task_slot      (task_slot),
        .task_period    (task_period),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .result_strobe  (result_strobe),
        .status         (status),
        .dispatch_valid (dispatch_valid),
        .dispatch_slot  (dispatch_slot),
        .tick_value     (tick_value),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_outcome(input logic [STATUS_W-1:0] st, input logic dv,
                                         input logic [DSLOT_W-1:0] slot,
                                         input logic [TICK_W-1:0] ticks, input logic last);
        outcome_t res;
        res.status         = st;
        res.dispatch_valid = dv;
        res.dispatch_slot  = slot;
        res.tick_value     = ticks;
        res.last_result    = last;
        pending_outcomes.push_back(res);
    endfunction

    function automatic void predict_outcome(input logic [ACTION_W-1:0] act,
                                            input logic [SLOT_IN_W-1:0] slot,
                                            input logic [PERIOD_W-1:0] period);
        status_t          st;
        logic [SLOTS-1:0] due;
        int               last_due;
        logic             any_task;
        st       = ST_OK;
        due      = '0;
        last_due = -1;
        any_task = 1'b0;
        case (act)
            ACT_TICK:
            begin
                if (sched_running)
                begin
                    sched_ticks = sched_ticks + 32'd1;
                    if (sched_ticks >= sched_wrap)
                        sched_ticks = '0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (sched_valid[i] && sched_period[i] != 0 &&
                            (sched_ticks % {16'd0, sched_period[i]}) == 0)
                        begin
                            due[i]   = 1'b1;
                            last_due = i;
                        end
                    end
                end
                else
                    st = ST_BAD_STATE;
            end
            ACT_CREATE:
            begin
                if (period == 0)
                    st = ST_ZERO_PERIOD;
                else if (slot >= SLOTS)
                    st = ST_RANGE;
                else if (sched_valid[slot])
                    st = ST_TAKEN;
                else
                begin
                    sched_valid[slot]  = 1'b1;
                    sched_period[slot] = period;
                end
            end
            ACT_DELETE:
            begin
                if (slot >= SLOTS)
                    st = ST_RANGE;
                else if (!sched_valid[slot])
                    st = ST_NOT_FOUND;
                else
                    sched_valid[slot] = 1'b0;
            end
            ACT_MODIFY:
            begin
                if (period == 0)
                    st = ST_ZERO_PERIOD;
                else if (slot >= SLOTS)
                    st = ST_RANGE;
                else if (!sched_valid[slot])
                    st = ST_NOT_FOUND;
                else
                    sched_period[slot] = period;
            end
            ACT_START:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (sched_valid[i])
                        any_task = 1'b1;
                if (!any_task)
                    st = ST_NO_TASKS;
                else if (sched_running)
                    st = ST_BAD_STATE;
                else
                    sched_running = 1'b1;
            end
            ACT_STOP:
            begin
                if (!sched_running)
                    st = ST_BAD_STATE;
                else
                begin
                    sched_running = 1'b0;
                    sched_ticks   = '0;
                end
            end
            default:
                st = ST_BAD_STATE;
        endcase
        if (last_due >= 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (due[i])
                    push_outcome(ST_OK, 1'b1, DSLOT_W'(i), sched_ticks, i == last_due);
        end
        else
            push_outcome(st, 1'b0, '0, sched_ticks, 1'b1);
    endfunction

    task automatic check_result;
        outcome_t exp;
        results_seen++;
        if (pending_outcomes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result status=%0d dv=%0b slot=%0d tick=%0d last=%0b",
                     $time, status, dispatch_valid, dispatch_slot, tick_value, last_result);
        end
        else
        begin
            exp = pending_outcomes.pop_front();
            if (exp.dispatch_valid)
                dispatches_seen++;
            if (status !== exp.status || dispatch_valid !== exp.dispatch_valid ||
                dispatch_slot !== exp.dispatch_slot || tick_value !== exp.tick_value ||
                last_result !== exp.last_result)
            begin
                errors++;
                $display("%0t: mismatch expected status=%0d dv=%0b slot=%0d tick=%0d last=%0b",
                         $time, exp.status, exp.dispatch_valid, exp.dispatch_slot,
                         exp.tick_value, exp.last_result);
                $display("%0t:          actual status=%0d dv=%0b slot=%0d tick=%0d last=%0b",
                         $time, status, dispatch_valid, dispatch_slot, tick_value,
                         last_result);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
                check_result();
            if (cfg_wr_en)
                sched_wrap = cfg_wr_data;
            if (start && !busy)
            begin
                items_accepted++;
                predict_outcome(action, task_slot, task_period);
                if (item_typed)
                begin
                    void'(pending_outcomes.pop_back());
                    push_outcome(item_status, 1'b0, '0, item_tick, 1'b1);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit of %0d reached", $time, CYCLE_LIMIT);
            $display("periodic_task_dispatcher_test: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_IN_W-1:0] slot,
                             input logic [PERIOD_W-1:0] period, input logic typed,
                             input status_t st, input logic [TICK_W-1:0] ticks);
        @(negedge clk);
        start       = 1'b1;
        action      = act;
        task_slot   = slot;
        task_period = period;
        item_typed  = typed;
        item_status = st;
        item_tick   = ticks;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic settle;
        @(negedge clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0 || busy)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_wrap(input logic [TICK_W-1:0] limit);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = limit;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        wrap_settings++;
    endtask

    task automatic random_item(input bit calm);
        int                   pick;
        logic [ACTION_W-1:0]  act;
        logic [SLOT_IN_W-1:0] slot;
        logic [PERIOD_W-1:0]  period;
        pick   = $urandom_range(0, 99);
        slot   = SLOT_IN_W'($urandom_range(0, SLOTS - 1));
        period = ($urandom_range(0, 5) == 0) ? PERIOD_W'($urandom)
                                             : PERIOD_W'($urandom_range(1, 12));
        if (pick < 45)
            act = ACT_TICK;
        else if (pick < 60)
            act = ACT_CREATE;
        else if (pick < 68)
            act = ACT_DELETE;
        else if (pick < 76)
            act = ACT_MODIFY;
        else if (pick < 84)
            act = ACT_START;
        else if (pick < 88)
            act = ACT_STOP;
        else
        begin
            act    = ACTION_W'($urandom);
            slot   = SLOT_IN_W'($urandom);
            period = $urandom_range(0, 1) ? '0 : PERIOD_W'($urandom);
        end
        if (!calm && $urandom_range(0, 3) == 0)
            idle($urandom_range(1, 12));
        send_item(act, slot, period, 1'b0, ST_OK, '0);
    endtask

    initial
    begin
        int directed_count;
        int done;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_TICK;
        task_slot   = '0;
        task_period = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        item_typed  = 1'b0;
        item_status = ST_OK;
        item_tick   = '0;
        cycle_count = 0;
        errors      = 0;
        items_accepted  = 0;
        results_seen    = 0;
        dispatches_seen = 0;
        wrap_settings   = 0;
        done            = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sched_valid[i]  = 1'b0;
            sched_period[i] = '0;
        end
        sched_ticks   = '0;
        sched_running = 1'b0;
        sched_wrap    = WRAP_LIMIT_RESET;

        directed_rows = '{
            '{ACT_TICK,    4'd0,  16'd0,     1'b1, ST_BAD_STATE,   32'd0},
            '{ACT_START,   4'd0,  16'd0,     1'b1, ST_NO_TASKS,    32'd0},
            '{ACT_STOP,    4'd0,  16'd0,     1'b1, ST_BAD_STATE,   32'd0},
            '{ACT_CREATE,  4'd0,  16'd0,     1'b1, ST_ZERO_PERIOD, 32'd0},
            '{ACT_CREATE,  4'd15, 16'd5,     1'b1, ST_RANGE,       32'd0},
            '{ACT_CREATE,  4'd8,  16'd0,     1'b1, ST_ZERO_PERIOD, 32'd0},
            '{ACT_DELETE,  4'd9,  16'd0,     1'b1, ST_RANGE,       32'd0},
            '{ACT_DELETE,  4'd3,  16'd0,     1'b1, ST_NOT_FOUND,   32'd0},
            '{ACT_MODIFY,  4'd2,  16'd0,     1'b1, ST_ZERO_PERIOD, 32'd0},
            '{ACT_MODIFY,  4'd12, 16'd7,     1'b1, ST_RANGE,       32'd0},
            '{ACT_MODIFY,  4'd2,  16'd7,     1'b1, ST_NOT_FOUND,   32'd0},
            '{ACT_SPARE_A, 4'd15, 16'hFFFF,  1'b1, ST_BAD_STATE,   32'd0},
            '{ACT_SPARE_B, 4'd0,  16'd1,     1'b1, ST_BAD_STATE,   32'd0},
            '{ACT_CREATE,  4'd0,  16'd1,     1'b1, ST_OK,          32'd0},
            '{ACT_CREATE,  4'd0,  16'd3,     1'b1, ST_TAKEN,       32'd0},
            '{ACT_CREATE,  4'd7,  16'hFFFF,  1'b1, ST_OK,          32'd0},
            '{ACT_CREATE,  4'd3,  16'd2,     1'b1, ST_OK,          32'd0},
            '{ACT_START,   4'd0,  16'd0,     1'b1, ST_OK,          32'd0},
            '{ACT_START,   4'd0,  16'd0,     1'b1, ST_BAD_STATE,   32'd0},
            '{ACT_TICK,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_TICK,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_MODIFY,  4'd3,  16'd3,     1'b0, ST_OK,          32'd0},
            '{ACT_TICK,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_DELETE,  4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_TICK,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_STOP,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0},
            '{ACT_TICK,    4'd0,  16'd0,     1'b0, ST_OK,          32'd0}
        };

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if ($urandom_range(0, 3) == 0)
                idle($urandom_range(1, 12));
            send_item(directed_rows[r].action, directed_rows[r].slot, directed_rows[r].period,
                      directed_rows[r].typed, directed_rows[r].status, directed_rows[r].tick);
        end
        directed_count = DIRECTED_ROWS;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_wrap(32'd1);
                1:       write_wrap($urandom_range(2, 20));
                2:       write_wrap(32'hFFFF_FFFF);
                default: write_wrap($urandom_range(3, 7));
            endcase
            if (p == 0)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    send_item(ACT_CREATE, SLOT_IN_W'(s), PERIOD_W'($urandom_range(1, 4)),
                              1'b0, ST_OK, '0);
                    done++;
                end
                send_item(ACT_START, '0, '0, 1'b0, ST_OK, '0);
                done++;
            end
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                random_item(done >= RANDOM_ITEMS - CALM_ITEMS);
                done++;
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Ran %0d items (%0d from the directed table) under %0d wrap limits.",
                 items_accepted, directed_count, wrap_settings);
        $display("Checked %0d results, %0d of them task dispatches; %0d errors.",
                 results_seen, dispatches_seen, errors);
        if (errors == 0)
            $display("periodic_task_dispatcher_test: PASS");
        else
            $display("periodic_task_dispatcher_test: FAIL");
        $finish;
    end

endmodule
